// ===== rtl/fmc_pkg.sv =====
// Shared types, constants and helpers for the file magic classifier.
package fmc_pkg;

	localparam int CountW = 12;
	localparam logic [CountW-1:0] MAX_BYTES = 12'd2048;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW = $clog2(QueueDepth);

	// file type codes
	localparam logic [4:0] FT_EMPTY  = 5'd0;
	localparam logic [4:0] FT_ELF    = 5'd1;
	localparam logic [4:0] FT_SCRIPT = 5'd2;
	localparam logic [4:0] FT_SQFS_L = 5'd3;
	localparam logic [4:0] FT_SQFS_B = 5'd4;
	localparam logic [4:0] FT_XZ     = 5'd5;
	localparam logic [4:0] FT_GZIP   = 5'd6;
	localparam logic [4:0] FT_BZIP2  = 5'd7;
	localparam logic [4:0] FT_ZSTD   = 5'd8;
	localparam logic [4:0] FT_PNG    = 5'd9;
	localparam logic [4:0] FT_JPEG   = 5'd10;
	localparam logic [4:0] FT_GIF    = 5'd11;
	localparam logic [4:0] FT_PDF    = 5'd12;
	localparam logic [4:0] FT_ZIP    = 5'd13;
	localparam logic [4:0] FT_CPIO   = 5'd14;
	localparam logic [4:0] FT_MBR    = 5'd15;
	localparam logic [4:0] FT_TEXT   = 5'd16;
	localparam logic [4:0] FT_DATA   = 5'd17;

	localparam logic [15:0] ELF_MACH_SH = 16'd42;
	localparam logic [7:0] ELF_CLASS_64 = 8'd2;
	localparam logic [7:0] ELF_DATA_MSB = 8'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  file_type;
		logic        elf_wide;
		logic        elf_big_endian;
		logic [15:0] elf_machine;
		logic        elf_is_sh;
	} out_item_t;

	// everything the back end needs about one finished file
	typedef struct packed {
		logic [7:0][7:0]    hdr;
		logic [1:0][7:0]    mach;
		logic [1:0][7:0]    boot;
		logic [CountW-1:0]  count;
		logic               text_ok;
	} summary_t;

	// capture state at the start of a file
	localparam summary_t SUM_RESET = '{hdr: '0, mach: '0, boot: '0, count: '0,
		text_ok: 1'b1};

	function automatic logic byte_is_text(input logic [7:0] c);
		logic ctl_ok;
		ctl_ok = (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09) ||
			(c == 8'h0c) || (c == 8'h08);
		return (c != 8'h00) && ((c >= 8'h20) || ctl_ok);
	endfunction

endpackage

// ===== rtl/fmc_front.sv =====
// Front end: captures header bytes, count and text flag, emits a file summary.
module fmc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  fmc_pkg::in_item_t   item,
	output logic                sum_push,
	output fmc_pkg::summary_t   sum
);

	fmc_pkg::summary_t st_q;
	fmc_pkg::summary_t st_n;
	logic              cap;

	assign cap = item.has_byte && (st_q.count < fmc_pkg::MAX_BYTES);

	always_comb begin
		st_n = st_q;
		if (cap) begin
			if (st_q.count < 12'd8) begin
				st_n.hdr[st_q.count[2:0]] = item.data_byte;
			end else if (st_q.count == 12'd18) begin
				st_n.mach[0] = item.data_byte;
			end else if (st_q.count == 12'd19) begin
				st_n.mach[1] = item.data_byte;
			end else if (st_q.count == 12'd510) begin
				st_n.boot[0] = item.data_byte;
			end else if (st_q.count == 12'd511) begin
				st_n.boot[1] = item.data_byte;
			end
			if (!fmc_pkg::byte_is_text(item.data_byte)) begin
				st_n.text_ok = 1'b0;
			end
			st_n.count = st_q.count + 12'd1;
		end
	end

	assign sum_push = accept && item.last;
	assign sum = st_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fmc_pkg::SUM_RESET;
		end else if (accept) begin
			if (item.last) begin
				st_q <= fmc_pkg::SUM_RESET;
			end else begin
				st_q <= st_n;
			end
		end
	end

endmodule

// ===== rtl/fmc_queue.sv =====
// Short queue of file summaries between the front and back ends.
module fmc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  fmc_pkg::summary_t wr_data,
	input  logic              rd,
	output fmc_pkg::summary_t rd_data,
	output logic              full,
	output logic              empty
);

	fmc_pkg::summary_t                 mem_q [fmc_pkg::QueueDepth];
	logic [fmc_pkg::QueuePtrW-1:0]     wr_ptr_q;
	logic [fmc_pkg::QueuePtrW-1:0]     rd_ptr_q;
	logic [fmc_pkg::QueuePtrW:0]       count_q;

	assign full = (count_q == (fmc_pkg::QueuePtrW+1)'(fmc_pkg::QueueDepth));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fmc_back.sv =====
// Back end: runs the signature checks on a summary and holds the result.
module fmc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sum_valid,
	input  fmc_pkg::summary_t   sum,
	output logic                sum_take,
	output logic                empty,
	input  logic                pop,
	output fmc_pkg::out_item_t  result
);

	fmc_pkg::out_item_t res_n;
	fmc_pkg::out_item_t res_q;
	logic               valid_q;
	logic [7:0][7:0]    h;
	logic [11:0]        n;
	logic [15:0]        mach;
	logic               big;

	assign h = sum.hdr;
	assign n = sum.count;
	assign big = (h[5] == fmc_pkg::ELF_DATA_MSB);
	assign mach = big ? {sum.mach[0], sum.mach[1]} : {sum.mach[1], sum.mach[0]};

	always_comb begin
		res_n = '0;
		if (n == '0) begin
			res_n.file_type = fmc_pkg::FT_EMPTY;
		end else if (n >= 12'd20 && h[0] == 8'h7f && h[1] == "E" && h[2] == "L" &&
			h[3] == "F") begin
			res_n.file_type = fmc_pkg::FT_ELF;
			res_n.elf_wide = (h[4] == fmc_pkg::ELF_CLASS_64);
			res_n.elf_big_endian = big;
			res_n.elf_machine = mach;
			res_n.elf_is_sh = (mach == fmc_pkg::ELF_MACH_SH);
		end else if (n >= 12'd2 && h[0] == "#" && h[1] == "!") begin
			res_n.file_type = fmc_pkg::FT_SCRIPT;
		end else if (n >= 12'd4 && h[0] == "h" && h[1] == "s" && h[2] == "q" &&
			h[3] == "s") begin
			res_n.file_type = fmc_pkg::FT_SQFS_L;
		end else if (n >= 12'd4 && h[0] == "s" && h[1] == "q" && h[2] == "s" &&
			h[3] == "h") begin
			res_n.file_type = fmc_pkg::FT_SQFS_B;
		end else if (n >= 12'd6 && h[0] == 8'hfd && h[1] == "7" && h[2] == "z" &&
			h[3] == "X" && h[4] == "Z" && h[5] == 8'h00) begin
			res_n.file_type = fmc_pkg::FT_XZ;
		end else if (n >= 12'd3 && h[0] == 8'h1f && h[1] == 8'h8b) begin
			res_n.file_type = fmc_pkg::FT_GZIP;
		end else if (n >= 12'd3 && h[0] == "B" && h[1] == "Z" && h[2] == "h") begin
			res_n.file_type = fmc_pkg::FT_BZIP2;
		end else if (n >= 12'd4 && h[0] == 8'h28 && h[1] == 8'hb5 && h[2] == 8'h2f &&
			h[3] == 8'hfd) begin
			res_n.file_type = fmc_pkg::FT_ZSTD;
		end else if (n >= 12'd8 && h[0] == 8'h89 && h[1] == "P" && h[2] == "N" &&
			h[3] == "G" && h[4] == 8'h0d && h[5] == 8'h0a && h[6] == 8'h1a &&
			h[7] == 8'h0a) begin
			res_n.file_type = fmc_pkg::FT_PNG;
		end else if (n >= 12'd3 && h[0] == 8'hff && h[1] == 8'hd8 && h[2] == 8'hff) begin
			res_n.file_type = fmc_pkg::FT_JPEG;
		end else if (n >= 12'd6 && h[0] == "G" && h[1] == "I" && h[2] == "F" &&
			h[3] == "8" && (h[4] == "7" || h[4] == "9") && h[5] == "a") begin
			res_n.file_type = fmc_pkg::FT_GIF;
		end else if (n >= 12'd5 && h[0] == "%" && h[1] == "P" && h[2] == "D" &&
			h[3] == "F" && h[4] == "-") begin
			res_n.file_type = fmc_pkg::FT_PDF;
		end else if (n >= 12'd4 && h[0] == "P" && h[1] == "K" && h[2] == 8'h03 &&
			h[3] == 8'h04) begin
			res_n.file_type = fmc_pkg::FT_ZIP;
		end else if (n >= 12'd6 && h[0] == "0" && h[1] == "7" && h[2] == "0" &&
			h[3] == "7" && h[4] == "0" && (h[5] == "1" || h[5] == "2")) begin
			res_n.file_type = fmc_pkg::FT_CPIO;
		end else if (n >= 12'd512 && sum.boot[0] == 8'h55 && sum.boot[1] == 8'haa) begin
			res_n.file_type = fmc_pkg::FT_MBR;
		end else begin
			res_n.file_type = sum.text_ok ? fmc_pkg::FT_TEXT : fmc_pkg::FT_DATA;
		end
	end

	assign sum_take = sum_valid && (!valid_q || pop);
	assign empty = !valid_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (sum_take) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sum_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/file_magic_classifier_top.sv =====
// File magic classifier: one byte per push, one result per file.
//
// Bytes of a file are pushed one per transaction, the final one flagged by
// last; a push with has_byte low and last high ends a file (an empty file if
// nothing came before). Input takes one transaction every cycle while full is
// low. On the last transaction a summary of the file goes into a two-entry
// queue; the back end classifies it into the result register, from which it
// can be popped. full rises only when both queue entries hold finished files
// and the result register is still occupied; bytes past MAX_BYTES are dropped.
module file_magic_classifier_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  fmc_pkg::in_item_t   item,
	output logic                empty,
	input  logic                pop,
	output fmc_pkg::out_item_t  result
);

	logic              accept;
	logic              sum_push;
	fmc_pkg::summary_t sum_in;
	fmc_pkg::summary_t sum_out;
	logic              q_empty;
	logic              sum_take;

	assign accept = push && !full;

	fmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.sum_push (sum_push),
		.sum      (sum_in)
	);

	fmc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (sum_push),
		.wr_data (sum_in),
		.rd      (sum_take),
		.rd_data (sum_out),
		.full    (full),
		.empty   (q_empty)
	);

	fmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (!q_empty),
		.sum       (sum_out),
		.sum_take  (sum_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== tb/file_magic_classifier_top_test.sv =====
// Testbench for the file magic classifier: signature, guard and random file traffic.
`timescale 1ns / 1ps

module file_magic_classifier_top_test;

	localparam int CycleLimit = 400000;
	localparam int IdlePct = 21;

	// header signatures, first file byte in the top used byte
	localparam logic [63:0] MAGIC_ELF    = 64'h7f454c46;
	localparam logic [63:0] MAGIC_SCRIPT = 64'h2321;
	localparam logic [63:0] MAGIC_SQFS_L = 64'h68737173;
	localparam logic [63:0] MAGIC_SQFS_B = 64'h73717368;
	localparam logic [63:0] MAGIC_XZ     = 64'hfd377a585a00;
	localparam logic [63:0] MAGIC_GZIP   = 64'h1f8b;
	localparam logic [63:0] MAGIC_BZIP2  = 64'h425a68;
	localparam logic [63:0] MAGIC_ZSTD   = 64'h28b52ffd;
	localparam logic [63:0] MAGIC_PNG    = 64'h89504e470d0a1a0a;
	localparam logic [63:0] MAGIC_JPEG   = 64'hffd8ff;
	localparam logic [63:0] MAGIC_GIF87  = 64'h474946383761;
	localparam logic [63:0] MAGIC_GIF89  = 64'h474946383961;
	localparam logic [63:0] MAGIC_PDF    = 64'h255044462d;
	localparam logic [63:0] MAGIC_ZIP    = 64'h504b0304;
	localparam logic [63:0] MAGIC_CPIO1  = 64'h303730373031;
	localparam logic [63:0] MAGIC_CPIO2  = 64'h303730373032;
	localparam logic [7:0]  BOOT_SIG_LO  = 8'h55;
	localparam logic [7:0]  BOOT_SIG_HI  = 8'haa;

	typedef enum int {END_ANY, END_ON_BYTE, END_NO_BYTE} file_end_t;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	fmc_pkg::in_item_t   item;
	logic                empty;
	logic                pop;
	fmc_pkg::out_item_t  result;

	// predictor copy of the capture state
	logic [7:0]  hdr_seen [8];
	logic [7:0]  mach_seen [2];
	logic [7:0]  boot_seen [2];
	logic [11:0] bytes_seen;
	bit          all_text;

	fmc_pkg::out_item_t expected_verdicts [$];
	logic [7:0]  file_buf [$];
	int          mismatches;
	int          items_sent;
	int          cycle_cnt;
	bit          no_idle;
	bit          pop_hold;

	file_magic_classifier_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("file_magic_classifier_top_test: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (pop_hold)
			pop = 1'b0;
		else
			pop = no_idle || ($urandom_range(0, 99) >= IdlePct);
	end

	// result checker
	always @(posedge clk) begin
		fmc_pkg::out_item_t exp_v;
		if (arst_n && pop && !empty) begin
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: type %0d", result.file_type);
			end else begin
				exp_v = expected_verdicts.pop_front();
				if (result.file_type !== exp_v.file_type ||
					result.elf_wide !== exp_v.elf_wide ||
					result.elf_big_endian !== exp_v.elf_big_endian ||
					result.elf_machine !== exp_v.elf_machine ||
					result.elf_is_sh !== exp_v.elf_is_sh) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: exp type %0d wide %0d be %0d mach %h sh %0d",
							exp_v.file_type, exp_v.elf_wide, exp_v.elf_big_endian,
							exp_v.elf_machine, exp_v.elf_is_sh);
						$display(" / got type %0d wide %0d be %0d mach %h sh %0d",
							result.file_type, result.elf_wide, result.elf_big_endian,
							result.elf_machine, result.elf_is_sh);
					end
				end
			end
		end
	end

	function automatic bit hdr_starts(input logic [63:0] pat, input int len);
		for (int i = 0; i < len; i++)
			if (hdr_seen[i] != pat[8*(len-1-i) +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit is_text_byte(input logic [7:0] c);
		if (c == 8'h00)
			return 1'b0;
		if (c >= 8'h20)
			return 1'b1;
		return c == 8'h0a || c == 8'h0d || c == 8'h09 || c == 8'h0c || c == 8'h08;
	endfunction

	task automatic clear_capture();
		foreach (hdr_seen[i])
			hdr_seen[i] = 8'h00;
		mach_seen[0] = 8'h00;
		mach_seen[1] = 8'h00;
		boot_seen[0] = 8'h00;
		boot_seen[1] = 8'h00;
		bytes_seen = '0;
		all_text = 1'b1;
	endtask

	// updates the capture state for one accepted transaction and, on the
	// last one, queues the classification of the file
	task automatic absorb_item(input fmc_pkg::in_item_t it);
		fmc_pkg::out_item_t v;
		logic [11:0] n;
		if (it.has_byte && bytes_seen < fmc_pkg::MAX_BYTES) begin
			if (bytes_seen < 8)
				hdr_seen[bytes_seen[2:0]] = it.data_byte;
			else if (bytes_seen == 18)
				mach_seen[0] = it.data_byte;
			else if (bytes_seen == 19)
				mach_seen[1] = it.data_byte;
			else if (bytes_seen == 510)
				boot_seen[0] = it.data_byte;
			else if (bytes_seen == 511)
				boot_seen[1] = it.data_byte;
			if (!is_text_byte(it.data_byte))
				all_text = 1'b0;
			bytes_seen++;
		end
		if (!it.last)
			return;
		v = '0;
		n = bytes_seen;
		if (n == 0)
			v.file_type = fmc_pkg::FT_EMPTY;
		else if (n >= 20 && hdr_starts(MAGIC_ELF, 4)) begin
			v.file_type = fmc_pkg::FT_ELF;
			v.elf_wide = hdr_seen[4] == fmc_pkg::ELF_CLASS_64;
			v.elf_big_endian = hdr_seen[5] == fmc_pkg::ELF_DATA_MSB;
			v.elf_machine = v.elf_big_endian ? {mach_seen[0], mach_seen[1]} :
				{mach_seen[1], mach_seen[0]};
			v.elf_is_sh = v.elf_machine == fmc_pkg::ELF_MACH_SH;
		end else if (n >= 2 && hdr_starts(MAGIC_SCRIPT, 2))
			v.file_type = fmc_pkg::FT_SCRIPT;
		else if (n >= 4 && hdr_starts(MAGIC_SQFS_L, 4))
			v.file_type = fmc_pkg::FT_SQFS_L;
		else if (n >= 4 && hdr_starts(MAGIC_SQFS_B, 4))
			v.file_type = fmc_pkg::FT_SQFS_B;
		else if (n >= 6 && hdr_starts(MAGIC_XZ, 6))
			v.file_type = fmc_pkg::FT_XZ;
		else if (n >= 3 && hdr_starts(MAGIC_GZIP, 2))
			v.file_type = fmc_pkg::FT_GZIP;
		else if (n >= 3 && hdr_starts(MAGIC_BZIP2, 3))
			v.file_type = fmc_pkg::FT_BZIP2;
		else if (n >= 4 && hdr_starts(MAGIC_ZSTD, 4))
			v.file_type = fmc_pkg::FT_ZSTD;
		else if (n >= 8 && hdr_starts(MAGIC_PNG, 8))
			v.file_type = fmc_pkg::FT_PNG;
		else if (n >= 3 && hdr_starts(MAGIC_JPEG, 3))
			v.file_type = fmc_pkg::FT_JPEG;
		else if (n >= 6 && (hdr_starts(MAGIC_GIF87, 6) || hdr_starts(MAGIC_GIF89, 6)))
			v.file_type = fmc_pkg::FT_GIF;
		else if (n >= 5 && hdr_starts(MAGIC_PDF, 5))
			v.file_type = fmc_pkg::FT_PDF;
		else if (n >= 4 && hdr_starts(MAGIC_ZIP, 4))
			v.file_type = fmc_pkg::FT_ZIP;
		else if (n >= 6 && (hdr_starts(MAGIC_CPIO1, 6) || hdr_starts(MAGIC_CPIO2, 6)))
			v.file_type = fmc_pkg::FT_CPIO;
		else if (n >= 512 && boot_seen[0] == BOOT_SIG_LO && boot_seen[1] == BOOT_SIG_HI)
			v.file_type = fmc_pkg::FT_MBR;
		else
			v.file_type = all_text ? fmc_pkg::FT_TEXT : fmc_pkg::FT_DATA;
		expected_verdicts.push_back(v);
		clear_capture();
	endtask

	// one transaction; push stays high afterwards until the next negedge
	task automatic send_item(input logic [7:0] b, input logic has, input logic lst);
		fmc_pkg::in_item_t it;
		it = '{data_byte: has ? b : 8'($urandom_range(0, 255)), has_byte: has, last: lst};
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		item = it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		absorb_item(it);
		if (has || lst)
			items_sent++;
	endtask

	task automatic send_file(input file_end_t how);
		bit no_byte_end;
		int n;
		n = file_buf.size();
		no_byte_end = (n == 0) || (how == END_NO_BYTE) ||
			(how == END_ANY && $urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++) begin
			// ignored filler transaction between bytes
			if ($urandom_range(0, 99) < 8)
				send_item(8'h00, 1'b0, 1'b0);
			send_item(file_buf[i], 1'b1, !no_byte_end && i == n - 1);
		end
		if (no_byte_end)
			send_item(8'h00, 1'b0, 1'b1);
		file_buf.delete();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic pick_signature(input logic [4:0] ft, input bit alt,
			output logic [63:0] pat, output int len);
		pat = '0;
		len = 0;
		case (ft)
			fmc_pkg::FT_ELF:    begin pat = MAGIC_ELF;    len = 4; end
			fmc_pkg::FT_SCRIPT: begin pat = MAGIC_SCRIPT; len = 2; end
			fmc_pkg::FT_SQFS_L: begin pat = MAGIC_SQFS_L; len = 4; end
			fmc_pkg::FT_SQFS_B: begin pat = MAGIC_SQFS_B; len = 4; end
			fmc_pkg::FT_XZ:     begin pat = MAGIC_XZ;     len = 6; end
			fmc_pkg::FT_GZIP:   begin pat = MAGIC_GZIP;   len = 2; end
			fmc_pkg::FT_BZIP2:  begin pat = MAGIC_BZIP2;  len = 3; end
			fmc_pkg::FT_ZSTD:   begin pat = MAGIC_ZSTD;   len = 4; end
			fmc_pkg::FT_PNG:    begin pat = MAGIC_PNG;    len = 8; end
			fmc_pkg::FT_JPEG:   begin pat = MAGIC_JPEG;   len = 3; end
			fmc_pkg::FT_GIF:    begin pat = alt ? MAGIC_GIF89 : MAGIC_GIF87; len = 6; end
			fmc_pkg::FT_PDF:    begin pat = MAGIC_PDF;    len = 5; end
			fmc_pkg::FT_ZIP:    begin pat = MAGIC_ZIP;    len = 4; end
			fmc_pkg::FT_CPIO:   begin pat = alt ? MAGIC_CPIO2 : MAGIC_CPIO1; len = 6; end
			default:            len = 0;
		endcase
	endtask

	task automatic put_magic(input logic [63:0] pat, input int len);
		for (int i = 0; i < len; i++)
			file_buf.push_back(pat[8*(len-1-i) +: 8]);
	endtask

	task automatic put_text(input int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 4))
					0: c = 8'h0a;
					1: c = 8'h0d;
					2: c = 8'h09;
					3: c = 8'h0c;
					default: c = 8'h08;
				endcase
			end else if ($urandom_range(0, 9) == 0)
				c = 8'($urandom_range(128, 255));
			else
				c = 8'($urandom_range(32, 126));
			file_buf.push_back(c);
		end
	endtask

	task automatic put_data(input int n);
		for (int i = 0; i < n; i++)
			file_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_run(input int n, input logic [7:0] b);
		for (int i = 0; i < n; i++)
			file_buf.push_back(b);
	endtask

	task automatic build_random_file();
		logic [4:0] ft;
		logic [63:0] pat;
		int plen;
		int body;
		int cut;
		bit big;
		ft = 5'($urandom_range(fmc_pkg::FT_ELF, fmc_pkg::FT_DATA));
		// boot sector files cost ~500 transactions, keep them rare
		if (ft == fmc_pkg::FT_MBR && $urandom_range(0, 3) != 0)
			ft = fmc_pkg::FT_TEXT;
		pick_signature(ft, 1'($urandom_range(0, 1)), pat, plen);
		put_magic(pat, plen);
		if (ft == fmc_pkg::FT_ELF)
			body = $urandom_range(12, 40);
		else if (ft == fmc_pkg::FT_MBR)
			body = $urandom_range(505, 530);
		else
			body = $urandom_range(0, 24);
		if (ft == fmc_pkg::FT_DATA || (ft != fmc_pkg::FT_TEXT && $urandom_range(0, 1)))
			put_data(body);
		else
			put_text(body);
		if (ft == fmc_pkg::FT_ELF) begin
			for (int k = 4; k < 6; k++)
				case ($urandom_range(0, 2))
					0: file_buf[k] = 8'd1;
					1: file_buf[k] = 8'd2;
					default: file_buf[k] = 8'($urandom_range(0, 255));
				endcase
			if (file_buf.size() >= 20 && $urandom_range(0, 1)) begin
				big = file_buf[5] == fmc_pkg::ELF_DATA_MSB;
				file_buf[18] = big ? 8'h00 : fmc_pkg::ELF_MACH_SH[7:0];
				file_buf[19] = big ? fmc_pkg::ELF_MACH_SH[7:0] : 8'h00;
			end
		end
		if (ft == fmc_pkg::FT_MBR && file_buf.size() >= 512 && $urandom_range(0, 3) != 0) begin
			file_buf[510] = BOOT_SIG_LO;
			file_buf[511] = BOOT_SIG_HI;
		end
		// broken signatures and truncated files
		if (plen > 0 && $urandom_range(0, 9) == 0)
			file_buf[$urandom_range(0, plen - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(0, plen + 1);
			while (file_buf.size() > cut)
				void'(file_buf.pop_back());
		end
	endtask

	task automatic test_magic_types();
		logic [63:0] pat;
		int plen;
		send_file(END_NO_BYTE);
		// 64-bit big-endian ELF, machine 42
		put_magic(MAGIC_ELF, 4);
		file_buf.push_back(fmc_pkg::ELF_CLASS_64);
		file_buf.push_back(fmc_pkg::ELF_DATA_MSB);
		put_run(12, 8'h00);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'h2a);
		put_run(4, 8'hff);
		send_file(END_ON_BYTE);
		// 32-bit little-endian ELF of exactly 20 bytes, ended without a byte
		put_magic(MAGIC_ELF, 4);
		put_run(14, 8'h01);
		file_buf.push_back(8'h2a);
		file_buf.push_back(8'h00);
		send_file(END_NO_BYTE);
		for (int ft = fmc_pkg::FT_SCRIPT; ft <= fmc_pkg::FT_CPIO; ft++)
			for (int alt = 0; alt < 2; alt++) begin
				if (alt == 1 && ft != fmc_pkg::FT_GIF && ft != fmc_pkg::FT_CPIO)
					continue;
				pick_signature(5'(ft), 1'(alt), pat, plen);
				put_magic(pat, plen);
				put_text(3);
				send_file(END_ANY);
			end
		put_text(12);
		send_file(END_ON_BYTE);
		file_buf.push_back(8'h41);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'hff);
		send_file(END_ON_BYTE);
	endtask

	task automatic test_length_guards();
		logic [63:0] pat;
		int plen;
		logic [7:0] probe [6];
		// ELF one byte short of the machine field
		put_magic(MAGIC_ELF, 4);
		put_text(15);
		send_file(END_ON_BYTE);
		// each signature one byte short
		for (int ft = fmc_pkg::FT_SCRIPT; ft <= fmc_pkg::FT_CPIO; ft++) begin
			pick_signature(5'(ft), 1'b0, pat, plen);
			put_magic(pat, plen - 1);
			send_file(END_ANY);
		end
		// gzip magic alone is still one byte short
		put_magic(MAGIC_GZIP, 2);
		send_file(END_ON_BYTE);
		// the allowed control characters keep a file text
		put_magic(64'h08090a0c0d61, 6);
		send_file(END_ON_BYTE);
		probe = '{8'h00, 8'h01, 8'h0b, 8'h1f, 8'h20, 8'hff};
		foreach (probe[i]) begin
			file_buf.push_back(probe[i]);
			send_file(END_ON_BYTE);
		end
	endtask

	task automatic test_long_files();
		put_data(510);
		file_buf.push_back(BOOT_SIG_LO);
		file_buf.push_back(BOOT_SIG_HI);
		send_file(END_NO_BYTE);
		put_text(600);
		file_buf[510] = BOOT_SIG_LO;
		file_buf[511] = BOOT_SIG_HI;
		send_file(END_ON_BYTE);
		// boot signature too late or incomplete
		put_text(510);
		file_buf.push_back(BOOT_SIG_LO);
		send_file(END_ON_BYTE);
		put_text(510);
		file_buf.push_back(BOOT_SIG_LO);
		file_buf.push_back(8'hab);
		send_file(END_ON_BYTE);
		// bytes beyond the count limit must not spoil the text flag
		put_text(int'(fmc_pkg::MAX_BYTES));
		put_run(60, 8'h00);
		send_file(END_NO_BYTE);
	endtask

	task automatic test_backpressure();
		pop_hold = 1'b1;
		fork
			begin
				repeat (40) @(posedge clk);
				pop_hold = 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++) begin
			if (i % 3 != 0)
				file_buf.push_back(8'($urandom_range(0, 255)));
			send_file(END_ANY);
		end
		wait_drained();
	endtask

	task automatic test_no_idle();
		int start;
		start = items_sent;
		no_idle = 1'b1;
		while (items_sent < start + 150) begin
			build_random_file();
			send_file(END_ANY);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_files();
		int start;
		start = items_sent;
		while (items_sent < start + 950) begin
			build_random_file();
			send_file(END_ANY);
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++) begin
			build_random_file();
			send_file(END_ANY);
		end
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			build_random_file();
			send_file(END_ANY);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		no_idle = 1'b0;
		pop_hold = 1'b0;
		mismatches = 0;
		items_sent = 0;
		cycle_cnt = 0;
		clear_capture();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_magic_types();
		test_length_guards();
		wait_drained();
		test_long_files();
		test_backpressure();
		test_no_idle();
		test_random_files();
		test_drain_pause();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("file_magic_classifier_top_test: PASS");
		else
			$display("file_magic_classifier_top_test: FAIL");
		$finish;
	end

endmodule
